/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RSS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rss assertion failed");

// next-cycle implication
`define RSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rss assertion failed");

`endif

/* rtl/rss_pkg.sv */
// package for the running sample statistics block: widths, field offsets, types
package rss_pkg;

   localparam int COUNT_WIDTH  = 16;
   localparam int SAMPLE_WIDTH = 32;

   localparam int NUM_WIDTH  = SAMPLE_WIDTH + COUNT_WIDTH + 1;
   localparam int REQ_WIDTH  = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_BITS   = COUNT_WIDTH + 6 * SAMPLE_WIDTH;
   localparam int RSP_WIDTH  = ((RSP_BITS + 7) / 8) * 8;
   localparam int MUL_CNT_W  = $clog2(COUNT_WIDTH);
   localparam int ITER_W     = $clog2(SAMPLE_WIDTH);

   localparam int F_COUNT = 0;
   localparam int F_FIRST = COUNT_WIDTH;
   localparam int F_MIN   = COUNT_WIDTH + SAMPLE_WIDTH;
   localparam int F_MAX   = COUNT_WIDTH + 2 * SAMPLE_WIDTH;
   localparam int F_MEAN  = COUNT_WIDTH + 3 * SAMPLE_WIDTH;

   localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX  = {COUNT_WIDTH{1'b1}};
   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_MEAN_START,
      ST_MEAN_DIV,
      ST_ABS_DIFF,
      ST_DEV_START,
      ST_DEV_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic start;
      logic negative;
   } div_ctl_type;

endpackage

/* rtl/running_sample_statistics.sv */
// top level of the running sample statistics block
//
// Each sample beat updates count, first sample, minimum, maximum, running mean,
// mean absolute deviation and last sample, and yields one result beat. For each
// item a bit-serial shift-add multiplier forms mean*count one count bit per
// cycle, then a shared divider resolves one quotient bit per cycle, first for
// the new mean and then for the deviation step. A finished result waits in an
// output register, so the next sample is taken while the previous result is
// unread.
module running_sample_statistics (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rss_pkg::REQ_WIDTH-1:0]  req_tdata,  // sample
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rss_pkg::RSP_WIDTH-1:0]  rsp_tdata   // sample_count, first_sample, minimum,
                                                      // maximum, mean, mean_abs_dev, last_sample
);
   import rss_pkg::*;

   state_type state_ff;
   state_type state_in;

   logic [COUNT_WIDTH-1:0]         count_ff;
   logic signed [SAMPLE_WIDTH-1:0] first_ff;
   logic signed [SAMPLE_WIDTH-1:0] min_ff;
   logic signed [SAMPLE_WIDTH-1:0] max_ff;
   logic signed [SAMPLE_WIDTH-1:0] mean_ff;
   logic [SAMPLE_WIDTH-1:0]        dev_ff;
   logic signed [SAMPLE_WIDTH-1:0] last_ff;

   logic [COUNT_WIDTH:0]           dvs_ff;
   logic signed [NUM_WIDTH-1:0]    acc_ff;
   logic signed [NUM_WIDTH-1:0]    mcand_ff;
   logic [COUNT_WIDTH-1:0]         mplier_ff;
   logic [MUL_CNT_W-1:0]           mul_cnt_ff;
   logic [SAMPLE_WIDTH-1:0]        absdiff_ff;

   logic                           rsp_tvalid_ff;
   logic [RSP_WIDTH-1:0]           rsp_data_ff;

   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           req_beat;
   logic                           out_load;
   logic [COUNT_WIDTH-1:0]         count_in;
   logic signed [SAMPLE_WIDTH:0]   diff;
   logic [SAMPLE_WIDTH:0]          diff_mag;
   logic signed [SAMPLE_WIDTH:0]   delta;
   logic [SAMPLE_WIDTH:0]          delta_mag;

   div_ctl_type                    div_ctl;
   logic [NUM_WIDTH-1:0]           div_numer;
   logic                           div_done;
   logic signed [SAMPLE_WIDTH-1:0] div_quo;

   assign sample   = $signed(req_tdata[SAMPLE_WIDTH-1:0]);
   assign req_beat = req_tvalid && req_tready;
   assign count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;

   assign diff      = {last_ff[SAMPLE_WIDTH-1], last_ff} - {mean_ff[SAMPLE_WIDTH-1], mean_ff};
   assign diff_mag  = diff[SAMPLE_WIDTH] ? -diff : diff;
   assign delta     = $signed({1'b0, absdiff_ff}) - $signed({1'b0, dev_ff});
   assign delta_mag = delta[SAMPLE_WIDTH] ? -delta : delta;

   rss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .numer    (div_numer),
      .divisor  (dvs_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (req_tvalid) state_in = ST_MUL;
         ST_MUL:        if (mul_cnt_ff == MUL_CNT_W'(COUNT_WIDTH - 1)) state_in = ST_MEAN_START;
         ST_MEAN_START: state_in = ST_MEAN_DIV;
         ST_MEAN_DIV:   if (div_done) state_in = ST_ABS_DIFF;
         ST_ABS_DIFF:   state_in = ST_DEV_START;
         ST_DEV_START:  state_in = ST_DEV_DIV;
         ST_DEV_DIV:    if (div_done) state_in = ST_FINISH;
         ST_FINISH:     if (!rsp_tvalid_ff || rsp_tready) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready       = 1'b0;
      out_load         = 1'b0;
      div_ctl.start    = 1'b0;
      div_ctl.negative = 1'b0;
      div_numer        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_MEAN_START: begin
            div_ctl.start    = 1'b1;
            div_ctl.negative = acc_ff[NUM_WIDTH-1];
            div_numer        = acc_ff[NUM_WIDTH-1] ? -acc_ff : acc_ff;
         end
         ST_DEV_START: begin
            div_ctl.start    = 1'b1;
            div_ctl.negative = delta[SAMPLE_WIDTH];
            div_numer        = NUM_WIDTH'(delta_mag);
         end
         ST_FINISH: begin
            out_load = !rsp_tvalid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         count_ff      <= '0;
         first_ff      <= '0;
         min_ff        <= SAMPLE_MAX;
         max_ff        <= SAMPLE_MIN;
         mean_ff       <= '0;
         dev_ff        <= '0;
         last_ff       <= '0;
      end else begin
         state_ff <= state_in;

         if (req_beat) begin
            if (count_ff == '0) first_ff <= sample;
            if (sample < min_ff) min_ff <= sample;
            if (sample > max_ff) max_ff <= sample;
            last_ff    <= sample;
            dvs_ff     <= {1'b0, count_ff} + 1'b1;
            acc_ff     <= NUM_WIDTH'(sample);
            mcand_ff   <= NUM_WIDTH'(mean_ff);
            mplier_ff  <= count_ff;
            mul_cnt_ff <= '0;
         end

         // shift-add over the count bits
         if (state_ff == ST_MUL) begin
            if (mplier_ff[0]) acc_ff <= acc_ff + mcand_ff;
            mcand_ff   <= mcand_ff <<< 1;
            mplier_ff  <= mplier_ff >> 1;
            mul_cnt_ff <= mul_cnt_ff + 1'b1;
         end

         if (state_ff == ST_MEAN_DIV && div_done) mean_ff <= div_quo;
         if (state_ff == ST_ABS_DIFF) absdiff_ff <= diff_mag[SAMPLE_WIDTH-1:0];
         if (state_ff == ST_DEV_DIV && div_done) dev_ff <= dev_ff + div_quo;

         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
            count_ff      <= count_in;
            rsp_data_ff   <= RSP_WIDTH'({last_ff, dev_ff, mean_ff, max_ff, min_ff,
                                         first_ff, count_in});
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/rss_div.sv */
// bit-serial sign-magnitude divider, one quotient bit per cycle
module rss_div (
   input  logic                                    clock,
   input  logic                                    reset,
   input  rss_pkg::div_ctl_type                    ctl,
   input  logic [rss_pkg::NUM_WIDTH-1:0]           numer,
   input  logic [rss_pkg::COUNT_WIDTH:0]           divisor,
   output logic                                    done,
   output logic signed [rss_pkg::SAMPLE_WIDTH-1:0] quotient
);
   import rss_pkg::*;

   logic                    busy_ff;
   logic                    done_ff;
   logic                    neg_ff;
   logic [COUNT_WIDTH:0]    rem_ff;
   logic [SAMPLE_WIDTH-1:0] quo_ff;
   logic [COUNT_WIDTH:0]    dvs_ff;
   logic [ITER_W-1:0]       iter_ff;

   logic [COUNT_WIDTH+1:0]  trial;
   logic [COUNT_WIDTH+1:0]  trial_sub;
   logic                    fits;

   assign trial     = {rem_ff, quo_ff[SAMPLE_WIDTH-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign fits      = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            iter_ff <= '0;
            neg_ff  <= ctl.negative;
            rem_ff  <= numer[NUM_WIDTH-1:SAMPLE_WIDTH];
            quo_ff  <= numer[SAMPLE_WIDTH-1:0];
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff  <= fits ? trial_sub[COUNT_WIDTH:0] : trial[COUNT_WIDTH:0];
            quo_ff  <= {quo_ff[SAMPLE_WIDTH-2:0], fits};
            iter_ff <= iter_ff + 1'b1;
            if (iter_ff == ITER_W'(SAMPLE_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

/* rtl/rss_checker.sv */
// port-level checker for the running sample statistics block, bound to the top
`include "assert_macros.svh"

module rss_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [rss_pkg::REQ_WIDTH-1:0] req_tdata,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [rss_pkg::RSP_WIDTH-1:0] rsp_tdata
);
   import rss_pkg::*;

   logic [COUNT_WIDTH-1:0]         rsp_count;
   logic signed [SAMPLE_WIDTH-1:0] rsp_min;
   logic signed [SAMPLE_WIDTH-1:0] rsp_max;
   logic signed [SAMPLE_WIDTH-1:0] rsp_mean;
   logic                           req_beat;

   assign rsp_count = rsp_tdata[F_COUNT +: COUNT_WIDTH];
   assign rsp_min   = rsp_tdata[F_MIN +: SAMPLE_WIDTH];
   assign rsp_max   = rsp_tdata[F_MAX +: SAMPLE_WIDTH];
   assign rsp_mean  = rsp_tdata[F_MEAN +: SAMPLE_WIDTH];
   assign req_beat  = req_tvalid && req_tready;

   `RSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))
   `RSS_ASSERT_SAME(a_count_nonzero, clock, reset, rsp_tvalid, rsp_count != '0)
   `RSS_ASSERT_SAME(a_mean_in_range, clock, reset, rsp_tvalid,
                    rsp_min <= rsp_mean && rsp_mean <= rsp_max)
   `RSS_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_beat, !req_tready)

endmodule

bind running_sample_statistics rss_checker u_rss_checker (.*);
